// ----- hdl/bpfd_pkg.sv -----
package bpfd_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_SAMPLES      = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EMPTY_CHECK_SAMPLES = 1'd1;

    localparam logic [7:0] WINDOW_SAMPLES_RESET      = 8'd55;
    localparam logic [7:0] EMPTY_CHECK_SAMPLES_RESET = 8'd5;

    localparam logic OP_START  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [1:0] LINES_IDLE = 2'b00;
    localparam logic [1:0] LINES_ONE  = 2'b01;
    localparam logic [1:0] LINES_ZERO = 2'b10;
    localparam logic [1:0] HALF_IDLE  = 2'b11;

    localparam logic [3:0] BIT_POS_FIRST    = 4'd1;
    localparam logic [3:0] BIT_POS_DATA     = 4'd4;
    localparam logic [3:0] BIT_POS_FULL     = 4'd12;
    localparam logic [3:0] CTRL_TOP_BIT_POS = 4'd3;
    localparam logic [3:0] DATA_TOP_BIT_POS = 4'd11;

    typedef struct packed {
        logic       op;
        logic [1:0] start_kind;
        logic [1:0] lines;
    } t_in_beat;

    typedef struct packed {
        logic [3:0] control;
        logic [7:0] data;
        logic       overflow;
        logic       was_empty;
    } t_out_beat;

endpackage

// ----- hdl/bit_pair_frame_decoder.sv -----
// A beat is captured in the input register and decoded from there into the result
// register, which then offers the frame result. Throughput: one beat per cycle
// unless a result is held up by a stall; input and result registers decouple both
// sides. A result waits only while the result register is still held by a stall.
// Synchronous active-low reset clears all decoder state, the held frame and the
// configuration registers (window 55 samples, empty check 5 samples).
module bit_pair_frame_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  bpfd_pkg::t_in_beat                  i_in_beat,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output bpfd_pkg::t_out_beat                 o_out_beat,
    input  logic                                i_cfg_we,
    input  logic [bpfd_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [bpfd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [7:0]          r_window_samples;
    logic [7:0]          r_empty_check_samples;

    logic                r_in_valid;
    bpfd_pkg::t_in_beat  r_in_beat;
    logic                r_out_valid;
    bpfd_pkg::t_out_beat r_out_beat;

    logic       r_in_frame,       n_in_frame;
    logic [7:0] r_sample_index,   n_sample_index;
    logic [3:0] r_bit_pos,        n_bit_pos;
    logic       r_half_pending,   n_half_pending;
    logic       r_first_half,     n_first_half;
    logic [1:0] r_previous_half,  n_previous_half;
    logic [3:0] r_work_control,   n_work_control;
    logic [7:0] r_work_data,      n_work_data;
    logic       r_work_overflow,  n_work_overflow;
    logic       r_seen_activity,  n_seen_activity;
    logic [3:0] r_held_control,   n_held_control;
    logic [7:0] r_held_data,      n_held_data;
    logic       r_held_overflow,  n_held_overflow;

    logic                has_result;
    bpfd_pkg::t_out_beat n_out_beat;
    logic                out_free;
    logic                go;

    always_comb begin
        logic       active;
        logic       half;
        logic       take;
        logic [3:0] ctrl_shift;
        logic [3:0] data_shift;

        n_in_frame      = r_in_frame;
        n_sample_index  = r_sample_index;
        n_bit_pos       = r_bit_pos;
        n_half_pending  = r_half_pending;
        n_first_half    = r_first_half;
        n_previous_half = r_previous_half;
        n_work_control  = r_work_control;
        n_work_data     = r_work_data;
        n_work_overflow = r_work_overflow;
        n_seen_activity = r_seen_activity;
        n_held_control  = r_held_control;
        n_held_data     = r_held_data;
        n_held_overflow = r_held_overflow;
        has_result      = 1'b0;
        active          = 1'b0;
        half            = 1'b0;
        take            = 1'b0;
        ctrl_shift      = bpfd_pkg::CTRL_TOP_BIT_POS - r_bit_pos;
        data_shift      = bpfd_pkg::DATA_TOP_BIT_POS - r_bit_pos;

        if (r_in_beat.op == bpfd_pkg::OP_START) begin
            n_in_frame      = 1'b1;
            n_sample_index  = '0;
            n_bit_pos       = bpfd_pkg::BIT_POS_FIRST;
            n_half_pending  = 1'b0;
            n_first_half    = 1'b0;
            n_previous_half = '0;
            n_work_control  = {r_in_beat.start_kind[1], 3'b000};
            n_work_data     = '0;
            n_work_overflow = 1'b0;
            n_seen_activity = 1'b0;
        end else if (r_in_frame) begin
            if (r_sample_index < r_empty_check_samples
                && r_in_beat.lines != bpfd_pkg::LINES_IDLE) begin
                n_seen_activity = 1'b1;
            end

            case (r_in_beat.lines)
                bpfd_pkg::LINES_ONE: begin
                    active = 1'b1;
                    half   = 1'b1;
                end
                bpfd_pkg::LINES_ZERO: begin
                    active = 1'b1;
                    half   = 1'b0;
                end
                default: begin
                    active = 1'b0;
                end
            endcase

            if (!active) begin
                n_previous_half = bpfd_pkg::HALF_IDLE;
            end else if (!r_half_pending) begin
                if ({1'b0, half} != r_previous_half) begin
                    n_first_half   = half;
                    n_half_pending = 1'b1;
                end
            end else if (half != r_first_half) begin
                n_previous_half = {1'b0, half};
                n_half_pending  = 1'b0;
                take            = 1'b1;
            end

            // second half of a pair decides the bit
            if (take) begin
                if (r_bit_pos >= bpfd_pkg::BIT_POS_FULL) begin
                    n_work_overflow = 1'b1;
                end else begin
                    if (r_bit_pos < bpfd_pkg::BIT_POS_DATA) begin
                        n_work_control[ctrl_shift[1:0]] = r_work_control[ctrl_shift[1:0]] | half;
                    end else begin
                        n_work_data[data_shift[2:0]] = r_work_data[data_shift[2:0]] | half;
                    end
                    n_bit_pos = r_bit_pos + 4'd1;
                end
            end

            n_sample_index = r_sample_index + 8'd1;
            if (n_sample_index == r_window_samples) begin
                has_result = 1'b1;
                n_in_frame = 1'b0;
                if (n_seen_activity) begin
                    n_held_control  = n_work_control;
                    n_held_data     = n_work_data;
                    n_held_overflow = n_work_overflow;
                end
            end
        end

        n_out_beat.control   = n_held_control;
        n_out_beat.data      = n_held_data;
        n_out_beat.overflow  = n_held_overflow;
        n_out_beat.was_empty = !n_seen_activity;
    end

    assign out_free    = !r_out_valid || !i_out_stall;
    assign go          = r_in_valid && (!has_result || out_free);
    assign o_in_stall  = r_in_valid && !go;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_samples      <= bpfd_pkg::WINDOW_SAMPLES_RESET;
            r_empty_check_samples <= bpfd_pkg::EMPTY_CHECK_SAMPLES_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bpfd_pkg::CFG_WINDOW_SAMPLES:      r_window_samples      <= i_cfg_data;
                bpfd_pkg::CFG_EMPTY_CHECK_SAMPLES: r_empty_check_samples <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_beat <= i_in_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go && has_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && has_result) begin
            r_out_beat <= n_out_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame      <= 1'b0;
            r_sample_index  <= '0;
            r_bit_pos       <= bpfd_pkg::BIT_POS_FIRST;
            r_half_pending  <= 1'b0;
            r_first_half    <= 1'b0;
            r_previous_half <= '0;
            r_work_control  <= '0;
            r_work_data     <= '0;
            r_work_overflow <= 1'b0;
            r_seen_activity <= 1'b0;
            r_held_control  <= '0;
            r_held_data     <= '0;
            r_held_overflow <= 1'b0;
        end else if (go) begin
            r_in_frame      <= n_in_frame;
            r_sample_index  <= n_sample_index;
            r_bit_pos       <= n_bit_pos;
            r_half_pending  <= n_half_pending;
            r_first_half    <= n_first_half;
            r_previous_half <= n_previous_half;
            r_work_control  <= n_work_control;
            r_work_data     <= n_work_data;
            r_work_overflow <= n_work_overflow;
            r_seen_activity <= n_seen_activity;
            r_held_control  <= n_held_control;
            r_held_data     <= n_held_data;
            r_held_overflow <= n_held_overflow;
        end
    end

    // bit position stays within the eleven-bit frame plus the overflow slot
    a_bit_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_pos >= bpfd_pkg::BIT_POS_FIRST && r_bit_pos <= bpfd_pkg::BIT_POS_FULL)
        else $error("bit position out of range");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_work_overflow |-> r_bit_pos == bpfd_pkg::BIT_POS_FULL)
        else $error("overflow flagged before frame was full");

    // a pending result always matches the held frame
    a_out_matches_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_beat.control == r_held_control
                         && r_out_beat.data == r_held_data
                         && r_out_beat.overflow == r_held_overflow))
        else $error("result beat differs from held frame");

endmodule
